>>> sv/lfh_pkg.sv
// lfh_pkg: shared types, constants and colour helper of the fire heat simulator
// no dependencies; imported by every other file of the block

package lfh_pkg;

  // default store depth
  localparam int MAX_CELLS_DEF = 256;

  // configuration reset values
  localparam logic [7:0] COOLING_RESET = 8'd55;
  localparam logic [7:0] CHANCE_RESET  = 8'd120;
  localparam logic [8:0] ACTIVE_RESET  = 9'd256;

  // configuration register indexes
  localparam logic [1:0] REG_COOLING = 2'd0;
  localparam logic [1:0] REG_CHANCE  = 2'd1;
  localparam logic [1:0] REG_ACTIVE  = 2'd2;

  // request opcodes
  typedef enum logic [1:0] {
    OP_COOL    = 2'd0,
    OP_DIFFUSE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  // reciprocal constants: x/3 for x < 768, x/255 for x < 65536
  localparam logic [9:0]  DIV3_RECIP   = 10'd683;
  localparam int          DIV3_SHIFT   = 11;
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int          DIV255_SHIFT = 23;

  // heat to 0..191 scaling
  localparam logic [7:0]  SCALE_MUL   = 8'd191;
  localparam logic [15:0] SCALE_ROUND = 16'd127;

  // colour ramp thresholds
  localparam logic [7:0] HOT_LIMIT  = 8'h80;
  localparam logic [7:0] WARM_LIMIT = 8'h40;
  localparam logic [7:0] FULL_LEVEL = 8'hFF;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // black, red, yellow, white ramp from a scaled heat of 0..191
  function automatic rgb_t heat_colour(logic [7:0] t);
    rgb_t       c;
    logic [7:0] ramp;
    ramp = {t[5:0], 2'b00};
    if (t > HOT_LIMIT) begin
      c = '{red: FULL_LEVEL, green: FULL_LEVEL, blue: ramp};
    end else if (t > WARM_LIMIT) begin
      c = '{red: FULL_LEVEL, green: ramp, blue: 8'd0};
    end else begin
      c = '{red: ramp, green: 8'd0, blue: 8'd0};
    end
    return c;
  endfunction

endpackage

>>> sv/lfh_divider.sv
// lfh_divider: restoring divider, one quotient bit per cycle
// depends on lfh_pkg (div_stat_t)

module lfh_divider import lfh_pkg::*; #(
  parameter int DW = 16,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output div_stat_t     stat,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dsr_r;

  logic [VW:0] trial;
  logic [VW:0] diff;
  logic        ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
        quo_r <= {quo_r[DW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat      = '{busy: busy_r, done: done_r};
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> sv/lfh_heat_mem.sv
// lfh_heat_mem: heat store, one write and one registered read per cycle
// depends on lfh_pkg only through the common import

module lfh_heat_mem import lfh_pkg::*; #(
  parameter int DEPTH = MAX_CELLS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/led_fire_heat_simulator_unit.sv
// led_fire_heat_simulator_unit: fire effect heat store with cool, diffuse/spark and colour read
// depends on lfh_pkg, lfh_divider, lfh_heat_mem

// One 8-bit heat value per led cell sits in a single-port-write, registered-read
// memory of MAX_CELLS entries. After reset a clearing pass writes zero to every
// entry, one a cycle, and in_ready stays low until it is done (configuration
// writes are still taken). Requests are handled one at a time by a sequencer
// that reads, modifies and writes the store. A cool request runs two divisions
// on the shared bit-serial divider (16 steps each, then a done strobe) and then
// a read and a write before the next request can be taken. A diffuse request
// streams the store downwards from the top active cell, one read and one write
// per cycle, then a read and a write of the spark cell when a spark lands. A read
// request passes through the two registered colour scaling multiplies; its colour
// waits in an output register so the next request can be taken while the result
// is still pending. Opcode 3 and requests to inactive cells (other than read)
// finish at once.

module led_fire_heat_simulator_unit import lfh_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_cell_index,
  input  logic [15:0] in_random_word,
  input  logic [7:0]  in_spark_roll,
  input  logic [2:0]  in_spark_position,
  input  logic [7:0]  in_spark_heat,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_level,
  output logic [7:0]  out_green_level,
  output logic [7:0]  out_blue_level,
  // configuration port
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);          // store address
  localparam int NW = $clog2(MAX_CELLS + 1);      // cell count
  localparam int WW = (NW > 9) ? NW : 9;          // common compare width
  localparam int VW = (NW > 12) ? NW : 12;        // divisor / remainder width
  localparam bit SPARK_ANY = (MAX_CELLS >= 8);    // every spark position is in the store

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_COOL_RD,
    S_COOL_WR,
    S_DIF_RUN,
    S_SPK_RD,
    S_SPK_WR,
    S_RD_WAIT,
    S_RD_MUL,
    S_RD_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [7:0] cooling_r;
  logic [7:0] chance_r;
  logic [8:0] active_r;

  // captured request
  logic [7:0]  idx_r;
  logic [15:0] rnd_r;
  logic [2:0]  pos_r;
  logic [7:0]  spk_heat_r;
  logic        spark_go_r;

  // diffuse walk
  logic [AW-1:0] rd_a_r;      // next address to read
  logic          iss_done_r;  // address zero already issued
  logic          dv_r;        // read data arrives this cycle
  logic [AW-1:0] va_r;        // address of arriving data
  logic          first_r;     // first arrival only primes the window
  logic [7:0]    hi_r;        // h[k-1] of the cell being written

  // clearing pass
  logic [AW-1:0] clr_r;

  // colour path
  logic [15:0] prod_r;
  logic [7:0]  t_r;

  // result register
  logic       out_valid_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;

  // store port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_q;

  // divider
  logic            div_start;
  logic [15:0]     div_dividend;
  logic [VW-1:0]   div_divisor;
  div_stat_t       div_stat;
  logic [15:0]     div_quo;
  logic [VW-1:0]   div_rem;

  logic [NW-1:0] n_w;
  logic [WW-1:0] act_w;
  logic          in_fire;
  opcode_t       in_op;
  logic          idx_ok;
  logic          spark_ok;
  logic [11:0]   cool_x10;
  logic [VW-1:0] cool_mod;
  logic [9:0]    dif_sum;
  logic [19:0]   dif_prod;
  logic [7:0]    cooled;
  logic [15:0]   scale_w;
  logic [31:0]   t_mul;
  rgb_t          colour;

  // active cell count clamped to 1..MAX_CELLS
  always_comb begin
    act_w = WW'(active_r);
    priority if (act_w == '0) begin
      n_w = NW'(1);
    end else if (act_w > WW'(MAX_CELLS)) begin
      n_w = NW'(MAX_CELLS);
    end else begin
      n_w = NW'(act_w);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_op    = opcode_t'(in_opcode);
  assign idx_ok   = WW'(in_cell_index) < WW'(n_w);
  assign spark_ok = (in_spark_roll < chance_r) &&
                    (SPARK_ANY || (in_spark_position < 3'(MAX_CELLS)));

  // cooldown modulus: cooling*10/n + 2, first division on the shared divider
  assign cool_x10 = {1'b0, cooling_r, 3'b000} + {3'b000, cooling_r, 1'b0};
  assign cool_mod = VW'(div_quo[11:0]) + VW'(2);

  assign div_start    = (in_fire && in_op == OP_COOL && idx_ok) ||
                        (state_r == S_DIV1 && div_stat.done);
  assign div_dividend = (state_r == S_IDLE) ? 16'(cool_x10) : rnd_r;
  assign div_divisor  = (state_r == S_IDLE) ? VW'(n_w) : cool_mod;

  // diffuse: (h[k-1] + 2*h[k-2]) / 3 by reciprocal multiply
  assign dif_sum  = {2'b00, hi_r} + {1'b0, mem_q, 1'b0};
  assign dif_prod = 20'(dif_sum) * 20'(DIV3_RECIP);

  // cool: saturating subtract of the remainder
  assign cooled = (div_rem > VW'(mem_q)) ? 8'd0 : (mem_q - div_rem[7:0]);

  // colour scaling: round(h*191/255) over two registered multiplies
  assign scale_w = 16'(mem_q) * 16'(SCALE_MUL) + SCALE_ROUND;
  assign t_mul   = 32'(prod_r) * 32'(DIV255_RECIP);
  assign colour  = heat_colour(t_r);

  // store read address
  always_comb begin
    unique case (state_r)
      S_IDLE:    mem_raddr = AW'(in_cell_index);
      S_DIF_RUN: mem_raddr = rd_a_r;
      S_SPK_RD:  mem_raddr = AW'(pos_r);
      default:   mem_raddr = AW'(idx_r);
    endcase
  end

  // store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_r);
    mem_wdata = cooled;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 8'd0;
      end
      S_COOL_WR: begin
        mem_we = 1'b1;
      end
      S_DIF_RUN: begin
        mem_we    = dv_r && !first_r;
        mem_waddr = va_r + AW'(2);
        mem_wdata = dif_prod[DIV3_SHIFT+7:DIV3_SHIFT];
      end
      S_SPK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = mem_q + spk_heat_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooling_r <= COOLING_RESET;
      chance_r  <= CHANCE_RESET;
      active_r  <= ACTIVE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_COOLING: cooling_r <= cfg_data[7:0];
        REG_CHANCE:  chance_r  <= cfg_data[7:0];
        REG_ACTIVE:  active_r  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      iss_done_r  <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      // colour stage refills the register itself
      if (out_valid_r && out_ready && state_r != S_RD_OUT) begin
        out_valid_r <= 1'b0;
      end
      dv_r <= (state_r == S_DIF_RUN) && !iss_done_r;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAX_CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            idx_r      <= in_cell_index;
            rnd_r      <= in_random_word;
            pos_r      <= in_spark_position;
            spk_heat_r <= in_spark_heat;
            spark_go_r <= spark_ok;
            unique case (in_op)
              OP_COOL: begin
                if (idx_ok) begin
                  state_r <= S_DIV1;
                end
              end
              OP_DIFFUSE: begin
                if (n_w >= NW'(3)) begin
                  rd_a_r     <= AW'(n_w - NW'(2));
                  iss_done_r <= 1'b0;
                  first_r    <= 1'b1;
                  state_r    <= S_DIF_RUN;
                end else if (spark_ok) begin
                  state_r <= S_SPK_RD;
                end
              end
              OP_READ: begin
                if (idx_ok) begin
                  state_r <= S_RD_WAIT;
                end else begin
                  t_r     <= 8'd0;
                  state_r <= S_RD_OUT;
                end
              end
              OP_NOP: ;
              default: ;
            endcase
          end
        end
        S_DIV1: begin
          if (div_stat.done) begin
            state_r <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_stat.done) begin
            state_r <= S_COOL_RD;
          end
        end
        S_COOL_RD: begin
          state_r <= S_COOL_WR;
        end
        S_COOL_WR: begin
          state_r <= S_IDLE;
        end
        S_DIF_RUN: begin
          // issue side walks down to address zero
          if (!iss_done_r) begin
            va_r <= rd_a_r;
            if (rd_a_r == '0) begin
              iss_done_r <= 1'b1;
            end else begin
              rd_a_r <= rd_a_r - AW'(1);
            end
          end
          // arrival side slides the two-cell window
          if (dv_r) begin
            hi_r    <= mem_q;
            first_r <= 1'b0;
            if (va_r == '0) begin
              state_r <= spark_go_r ? S_SPK_RD : S_IDLE;
            end
          end
        end
        S_SPK_RD: begin
          state_r <= S_SPK_WR;
        end
        S_SPK_WR: begin
          state_r <= S_IDLE;
        end
        S_RD_WAIT: begin
          prod_r  <= scale_w;
          state_r <= S_RD_MUL;
        end
        S_RD_MUL: begin
          t_r     <= t_mul[DIV255_SHIFT+7:DIV255_SHIFT];
          state_r <= S_RD_OUT;
        end
        S_RD_OUT: begin
          // hold until the result register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            red_r       <= colour.red;
            green_r     <= colour.green;
            blue_r      <= colour.blue;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

  lfh_divider #(
    .DW (16),
    .VW (VW)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  lfh_heat_mem #(
    .DEPTH (MAX_CELLS)
  ) u_heat_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // diffuse never overwrites a cell that is still to be read
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIF_RUN && mem_we) |-> (mem_waddr > mem_raddr))
    else $error("diffuse write overtook the read pointer");

  // divider only finishes while a cool request waits on it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("stray divider completion");

  // no new request while the divider is still running
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy)
    else $error("request taken with divider busy");

  // a result only appears out of the colour stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RD_OUT))
    else $error("result raised outside the colour stage");

  // cool write follows its read after both divisions
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COOL_WR) |-> ($past(state_r) == S_COOL_RD && $past(state_r, 2) == S_DIV2))
    else $error("cool write out of sequence");

endmodule

>>> test/testbench.sv
// testbench for led_fire_heat_simulator_unit: cool, diffuse/spark and colour read requests
// self-checking against an in-bench heat model; depends on lfh_pkg and the block's rtl

module testbench import lfh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // no register sits at this index, writes to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // cycles with no handshake on either channel before the run is given up
  localparam int STALL_LIMIT = 4000;
  // quiet time that covers the longest diffuse pass at full depth
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 140;

  typedef struct {
    opcode_t     op;
    logic [7:0]  cell_no;
    logic [15:0] rnd;
    logic [7:0]  roll;
    logic [2:0]  pos;
    logic [7:0]  heat;
  } fire_req_t;

  // heat store, register copy and pending colours of the block
  class heat_model;
    logic [7:0]  heat [MAX_CELLS_DEF];
    logic [7:0]  cooling;
    logic [7:0]  chance;
    logic [8:0]  active;
    rgb_t        colour_q[$];
    int unsigned mismatches;
    int unsigned colours_seen;

    function new();
      foreach (heat[i]) heat[i] = 8'd0;
      cooling = COOLING_RESET;
      chance = CHANCE_RESET;
      active = ACTIVE_RESET;
      mismatches = 0;
      colours_seen = 0;
    endfunction

    function int unsigned live_cells();
      int unsigned n;
      n = active;
      if (n < 1) n = 1;
      if (n > MAX_CELLS_DEF) n = MAX_CELLS_DEF;
      return n;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        REG_COOLING: cooling = val[7:0];
        REG_CHANCE:  chance = val[7:0];
        REG_ACTIVE:  active = val;
        default: ;
      endcase
    endfunction

    // scale heat to 0..191 with rounding, then pick the ramp segment
    function rgb_t colour_of(logic [7:0] h);
      int unsigned t;
      logic [7:0]  ramp;
      rgb_t        c;
      t = (int'(h) * 191 + 127) / 255;
      ramp = 8'((t & 'h3F) << 2);
      if (t > HOT_LIMIT) begin
        c.red = FULL_LEVEL; c.green = FULL_LEVEL; c.blue = ramp;
      end else if (t > WARM_LIMIT) begin
        c.red = FULL_LEVEL; c.green = ramp; c.blue = 8'd0;
      end else begin
        c.red = ramp; c.green = 8'd0; c.blue = 8'd0;
      end
      return c;
    endfunction

    function void apply_request(fire_req_t r);
      int unsigned n;
      int unsigned span;
      int unsigned drop;
      int unsigned s;
      rgb_t        dark;
      n = live_cells();
      dark = '{red: 8'd0, green: 8'd0, blue: 8'd0};
      case (r.op)
        OP_COOL: begin
          // inactive cells are left alone
          if (r.cell_no < n) begin
            span = int'(cooling) * 10 / n + 2;
            drop = r.rnd % span;
            heat[r.cell_no] = (drop > heat[r.cell_no]) ? 8'd0 :
                              8'(heat[r.cell_no] - drop);
          end
        end
        OP_DIFFUSE: begin
          // top down, in place, so each cell sees the old values below it
          for (int k = n - 1; k >= 2; k--) begin
            s = heat[k-1] + 2 * heat[k-2];
            heat[k] = 8'(s / 3);
          end
          // spark lands even beyond the active cells, sum wraps
          if (r.roll < chance) heat[r.pos] = heat[r.pos] + r.heat;
        end
        OP_READ: colour_q.push_back((r.cell_no < n) ? colour_of(heat[r.cell_no]) : dark);
        default: ;
      endcase
    endfunction

    function void check_colour(rgb_t got);
      rgb_t want;
      if (colour_q.size() == 0) begin
        $error("colour result with no read request pending: %0d/%0d/%0d",
               got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = colour_q.pop_front();
      colours_seen++;
      if (got.red !== want.red) begin
        $error("red_level: expected %0d, actual %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green_level: expected %0d, actual %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue_level: expected %0d, actual %0d", want.blue, got.blue);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [7:0]  in_cell_index;
  logic [15:0] in_random_word;
  logic [7:0]  in_spark_roll;
  logic [2:0]  in_spark_position;
  logic [7:0]  in_spark_heat;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red_level;
  logic [7:0]  out_green_level;
  logic [7:0]  out_blue_level;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  heat_model   model = new();
  int unsigned send_idle = 0;    // percent of cycles the sender holds back
  int unsigned recv_stall = 0;   // percent of cycles the receiver is not ready
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent = 0;

  // register settings per phase, extremes included; 511 and 0 exercise the clamp
  int cool_set   [PHASES] = '{55, 0, 255, 255, 128, 10, 200, 77};
  int chance_set [PHASES] = '{120, 255, 255, 0, 200, 255, 180, 1};
  int active_set [PHASES] = '{256, 8, 1, 2, 16, 511, 0, 40};

  led_fire_heat_simulator_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_cell_index     (in_cell_index),
    .in_random_word    (in_random_word),
    .in_spark_roll     (in_spark_roll),
    .in_spark_position (in_spark_position),
    .in_spark_heat     (in_spark_heat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_level     (out_red_level),
    .out_green_level   (out_green_level),
    .out_blue_level    (out_blue_level),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // both channels are observed at the rising edge: the result is checked first,
  // then an accepted request updates the model
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      model.check_colour('{red: out_red_level, green: out_green_level, blue: out_blue_level});
    if (rst_n && in_valid && in_ready)
      model.apply_request('{op: opcode_t'(in_opcode), cell_no: in_cell_index,
                            rnd: in_random_word, roll: in_spark_roll,
                            pos: in_spark_position, heat: in_spark_heat});
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog: the block has stopped taking or giving anything
  initial begin
    do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("timeout after %0d quiet cycles", quiet_cycles);
    $display("*** FAILED ***");
    $finish;
  end

  // every task below starts and ends just after a falling edge
  task automatic send_request(input fire_req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_opcode         = r.op;
    in_cell_index     = r.cell_no;
    in_random_word    = r.rnd;
    in_spark_roll     = r.roll;
    in_spark_position = r.pos;
    in_spark_heat     = r.heat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    if (r.op != OP_NOP) requests_sent++;
  endtask

  task automatic send(input opcode_t op, input logic [7:0] cell_no, input logic [15:0] rnd,
                      input logic [7:0] roll, input logic [2:0] pos, input logic [7:0] heat);
    send_request('{op: op, cell_no: cell_no, rnd: rnd, roll: roll, pos: pos, heat: heat});
  endtask

  // hold the sender until every colour is back
  task automatic wait_colours_drained();
    in_valid = 1'b0;
    while (model.colour_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // block idle: no colour pending and any cool or diffuse pass long finished
  task automatic settle();
    wait_colours_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = val;
    @(posedge clk);
    model.write_reg(idx, val);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // 8-bit registers get a random ninth bit, which must be dropped
  task automatic write_settings(input int cool, input int chance, input int active);
    write_reg(REG_COOLING, {1'($urandom), 8'(cool)});
    write_reg(REG_CHANCE, {1'($urandom), 8'(chance)});
    write_reg(REG_ACTIVE, 9'(active));
  endtask

  // random request biased towards active cells, small cool draws and spark heats of 160..254
  function automatic fire_req_t random_request();
    fire_req_t   r;
    int unsigned n;
    int unsigned pick;
    n = model.live_cells();
    pick = $urandom_range(0, 99);
    if (pick < 30) r.op = OP_COOL;
    else if (pick < 60) r.op = OP_DIFFUSE;
    else if (pick < 96) r.op = OP_READ;
    else r.op = OP_NOP;
    r.cell_no = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, n - 1)) : 8'($urandom);
    r.rnd  = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    r.roll = 8'($urandom);
    r.pos  = 3'($urandom);
    r.heat = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(160, 254)) : 8'($urandom);
    return r;
  endfunction

  initial begin
    int unsigned sent;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_opcode         = OP_NOP;
    in_cell_index     = 8'd0;
    in_random_word    = 16'd0;
    in_spark_roll     = 8'd0;
    in_spark_position = 3'd0;
    in_spark_heat     = 8'd0;
    cfg_write_en      = 1'b0;
    cfg_index         = REG_COOLING;
    cfg_data          = 9'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset settings: cleared store, spark edges, wrap, ignored opcode
    send(OP_READ, 8'd0, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_DIFFUSE, 8'd0, 16'd0, 8'd0, 3'd0, 8'd254);
    send(OP_READ, 8'd0, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_DIFFUSE, 8'd0, 16'd0, 8'd119, 3'd7, 8'd160);   // roll just under chance
    send(OP_DIFFUSE, 8'd0, 16'd0, 8'd120, 3'd1, 8'd200);   // roll equal, no spark
    send(OP_DIFFUSE, 8'd0, 16'd0, 8'd255, 3'd3, 8'd255);
    send(OP_READ, 8'd1, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_READ, 8'd2, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_READ, 8'd7, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_COOL, 8'd0, 16'hFFFF, 8'd0, 3'd0, 8'd0);
    send(OP_COOL, 8'd255, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_COOL, 8'd7, 16'd3, 8'd0, 3'd0, 8'd0);
    send(OP_NOP, 8'hFF, 16'hFFFF, 8'hFF, 3'd7, 8'hFF);
    send(OP_DIFFUSE, 8'd0, 16'd0, 8'd0, 3'd0, 8'd254);     // heat sum wraps
    send(OP_READ, 8'd0, 16'd0, 8'd0, 3'd0, 8'd0);

    // few cells active: inactive reads give black, inactive cools are ignored
    settle();
    write_settings(255, 255, 5);
    send(OP_READ, 8'd200, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_COOL, 8'd200, 16'd9, 8'd0, 3'd0, 8'd0);
    send(OP_DIFFUSE, 8'd0, 16'd0, 8'd0, 3'd6, 8'd255);     // spark past the active cells
    send(OP_READ, 8'd4, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_READ, 8'd6, 16'd0, 8'd0, 3'd0, 8'd0);
    send(OP_COOL, 8'd4, 16'hFFFF, 8'd0, 3'd0, 8'd0);
    send(OP_READ, 8'd255, 16'd0, 8'd0, 3'd0, 8'd0);

    // random phases, each with its own settings and one of four idling patterns
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_settings(cool_set[p], chance_set[p], active_set[p]);
      if (p == 6) write_reg(REG_UNUSED, 9'($urandom));
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 60; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 60; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      sent = requests_sent;
      while (requests_sent - sent < PHASE_REQUESTS) begin
        // mid-phase the sender holds off until the result side is empty
        if (requests_sent - sent == PHASE_REQUESTS / 2) begin
          wait_colours_drained();
          sent = sent - 1;
        end
        send_request(random_request());
      end
    end

    // drain and let the last diffuse pass finish
    send_idle = 0;
    wait_colours_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.colour_q.size() != 0) begin
      $error("%0d colour results never arrived", model.colour_q.size());
      model.mismatches += model.colour_q.size();
    end
    $display("ran %0d requests over %0d register settings, %0d colours checked",
             requests_sent, PHASES + 2, model.colours_seen);
    if (model.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", model.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
